### rtl/prtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtb_pkg
// shared widths, trig constants and the vertex word passed from front to back
// ----------------------------------------------------------------------------
package prtb_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;

  // sine and cosine are q1.15 held in 17 signed bits
  localparam int TRIG_BITS = 17;
  localparam int TRIG_FRAC = 15;
  localparam int ONE_Q15 = 1 << TRIG_FRAC;
  localparam int Q15_HALF = 1 << (TRIG_FRAC - 1);

  // datapath widths of the transform
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = TRIG_BITS + DIFF_BITS;
  localparam int SUM_BITS = PROD_BITS + 1;
  localparam int ROT_BITS = SUM_BITS - TRIG_FRAC;
  localparam int XLAT_BITS = ROT_BITS + 2;

  // polynomial sine over one quadrant, q1.30
  localparam int QUAD_BITS = ANGLE_BITS - 2;
  localparam int MUL_W = 31;
  localparam int Q30 = 30;
  localparam int TRIG_XSHIFT = Q30 - QUAD_BITS;
  localparam logic [MUL_W-1:0] TRIG_A = 31'd1686629713;
  localparam logic [MUL_W-1:0] TRIG_B = 31'd688904866;
  localparam logic [MUL_W-1:0] TRIG_C = 31'd76016977;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [DIFF_BITS-1:0]  dx;
    logic signed [DIFF_BITS-1:0]  dy;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         first;
    logic                         last;
  } vtx_entry_t;

endpackage

### rtl/prtb_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtb_trig
// sequenced sine and cosine of the rotation angle on one shared multiplier
// ----------------------------------------------------------------------------
module prtb_trig
  import prtb_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic                        busy,
  output logic signed [TRIG_BITS-1:0] cos_value,
  output logic signed [TRIG_BITS-1:0] sin_value
);

  localparam int ARG_BITS = QUAD_BITS + 1;
  localparam int TPROD_BITS = 2 * MUL_W;
  localparam int RND_BITS = MUL_W + 1 - TRIG_FRAC;
  localparam int MAG_BITS = TRIG_BITS - 1;
  localparam int Q_LEN = 1 << QUAD_BITS;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_TERM_C = 6'b000100,
    ST_TERM_B = 6'b001000,
    ST_TERM_A = 6'b010000,
    ST_ROUND  = 6'b100000
  } state_t;

  state_t                 state;
  logic                   second;
  logic [1:0]             quad;
  logic [QUAD_BITS-1:0]   rem;
  logic [MUL_W-1:0]       xv;
  logic [MUL_W-1:0]       x2;
  logic [MUL_W-1:0]       tv;
  logic [MAG_BITS-1:0]    mag_r;

  logic [MUL_W-1:0]       mul_a;
  logic [MUL_W-1:0]       mul_b;
  logic [TPROD_BITS-1:0]  prod;
  logic [MUL_W-1:0]       prod_q30;
  logic [MUL_W:0]         rnd;
  logic [RND_BITS-1:0]    rnd_mag;
  logic [MAG_BITS-1:0]    mag;
  logic [ARG_BITS-1:0]    arg_r;
  logic [ARG_BITS-1:0]    arg_c;
  logic signed [TRIG_BITS-1:0] sr;
  logic signed [TRIG_BITS-1:0] sc;

  assign busy = (state != ST_IDLE);

  always_comb begin
    mul_a = xv;
    mul_b = xv;
    case (state)
      ST_TERM_C: begin
        mul_a = TRIG_C;
        mul_b = x2;
      end
      ST_TERM_B: begin
        mul_a = TRIG_B - tv;
        mul_b = x2;
      end
      ST_TERM_A: begin
        mul_a = TRIG_A - tv;
        mul_b = xv;
      end
      default: ;
    endcase
    prod     = TPROD_BITS'(mul_a) * TPROD_BITS'(mul_b);
    prod_q30 = prod[MUL_W+Q30-1:Q30];
  end

  // round half up to q1.15 and clamp at one
  always_comb begin
    rnd     = (MUL_W + 1)'(tv) + (MUL_W + 1)'(Q15_HALF);
    rnd_mag = rnd[MUL_W:TRIG_FRAC];
    if (rnd_mag > RND_BITS'(ONE_Q15)) begin
      mag = MAG_BITS'(ONE_Q15);
    end else begin
      mag = rnd_mag[MAG_BITS-1:0];
    end
    sr = $signed({1'b0, mag_r});
    sc = $signed({1'b0, mag});
  end

  assign arg_r = ARG_BITS'(angle[QUAD_BITS-1:0]);
  assign arg_c = ARG_BITS'(Q_LEN) - ARG_BITS'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      second    <= 1'b0;
      cos_value <= TRIG_BITS'(ONE_Q15);
      sin_value <= '0;
    end else if (start) begin
      state  <= ST_SQUARE;
      second <= 1'b0;
    end else begin
      case (state)
        ST_SQUARE: state <= ST_TERM_C;
        ST_TERM_C: state <= ST_TERM_B;
        ST_TERM_B: state <= ST_TERM_A;
        ST_TERM_A: state <= ST_ROUND;
        ST_ROUND: begin
          if (!second) begin
            second <= 1'b1;
            state  <= ST_SQUARE;
          end else begin
            state <= ST_IDLE;
            // mag_r is sine of r, mag is sine of the quadrant complement
            case (quad)
              QUAD_0: begin
                sin_value <= sr;
                cos_value <= sc;
              end
              QUAD_1: begin
                sin_value <= sc;
                cos_value <= -sr;
              end
              QUAD_2: begin
                sin_value <= -sr;
                cos_value <= -sc;
              end
              default: begin
                sin_value <= -sc;
                cos_value <= sr;
              end
            endcase
          end
        end
        ST_IDLE: ;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad <= angle[ANGLE_BITS-1:QUAD_BITS];
      rem  <= angle[QUAD_BITS-1:0];
      xv   <= MUL_W'(arg_r) << TRIG_XSHIFT;
    end else begin
      case (state)
        ST_SQUARE: x2 <= prod_q30;
        ST_TERM_C: tv <= prod_q30;
        ST_TERM_B: tv <= prod_q30;
        ST_TERM_A: tv <= prod_q30;
        ST_ROUND: begin
          if (!second) begin
            mag_r <= mag;
            xv    <= MUL_W'(arg_c) << TRIG_XSHIFT;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/prtb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtb_front
// takes vertex words, latches the pivot at polygon start, forms the offsets
// ----------------------------------------------------------------------------
module prtb_front
  import prtb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       vertex_valid,
  output logic       vertex_stall,
  input  coord_t     vertex_x,
  input  coord_t     vertex_y,
  input  logic       vertex_last,
  input  logic       blocked,
  input  logic       pivot_mode,
  input  coord_t     fixed_pivot_x,
  input  coord_t     fixed_pivot_y,
  output logic       push,
  output vtx_entry_t push_entry
);

  logic   awaiting_first;
  coord_t pivot_x;
  coord_t pivot_y;
  coord_t piv_x_use;
  coord_t piv_y_use;

  assign vertex_stall = blocked;
  assign push         = vertex_valid && !blocked;

  always_comb begin
    if (awaiting_first) begin
      piv_x_use = pivot_mode ? fixed_pivot_x : vertex_x;
      piv_y_use = pivot_mode ? fixed_pivot_y : vertex_y;
    end else begin
      piv_x_use = pivot_x;
      piv_y_use = pivot_y;
    end
    push_entry.dx    = DIFF_BITS'(vertex_x) - DIFF_BITS'(piv_x_use);
    push_entry.dy    = DIFF_BITS'(vertex_y) - DIFF_BITS'(piv_y_use);
    push_entry.px    = piv_x_use;
    push_entry.py    = piv_y_use;
    push_entry.first = awaiting_first;
    push_entry.last  = vertex_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
    end else if (push) begin
      awaiting_first <= vertex_last;
    end
  end

  always_ff @(posedge clk) begin
    if (push && awaiting_first) begin
      pivot_x <= piv_x_use;
      pivot_y <= piv_y_use;
    end
  end

endmodule

### rtl/prtb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtb_queue
// small fifo of vertex words between the front and the transform pipeline
// ----------------------------------------------------------------------------
module prtb_queue
  import prtb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  vtx_entry_t push_entry,
  input  logic       pop,
  output logic       empty,
  output logic       full,
  output vtx_entry_t head
);

  vtx_entry_t           slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### rtl/prtb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtb_back
// rotate, round, translate, saturate, track the box and close the outline
// ----------------------------------------------------------------------------
module prtb_back
  import prtb_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  vtx_entry_t                  q_head,
  output logic                        q_pop,
  input  logic signed [TRIG_BITS-1:0] cos_value,
  input  logic signed [TRIG_BITS-1:0] sin_value,
  input  coord_t                      offset_x,
  input  coord_t                      offset_y,
  output logic                        result_valid,
  input  logic                        result_stall,
  output coord_t                      out_x,
  output coord_t                      out_y,
  output coord_t                      box_min_x,
  output coord_t                      box_min_y,
  output coord_t                      box_max_x,
  output coord_t                      box_max_y,
  output logic                        closing_point,
  output logic                        result_last
);

  // stage 1: products
  logic                        s1_valid;
  logic signed [PROD_BITS-1:0] s1_cdx;
  logic signed [PROD_BITS-1:0] s1_sdy;
  logic signed [PROD_BITS-1:0] s1_sdx;
  logic signed [PROD_BITS-1:0] s1_cdy;
  coord_t                      s1_px;
  coord_t                      s1_py;
  logic                        s1_first;
  logic                        s1_last;
  // stage 2: rounded rotation
  logic                        s2_valid;
  logic signed [ROT_BITS-1:0]  s2_rx;
  logic signed [ROT_BITS-1:0]  s2_ry;
  coord_t                      s2_px;
  coord_t                      s2_py;
  logic                        s2_first;
  logic                        s2_last;
  // stage 3: translated and saturated point
  logic                        s3_valid;
  coord_t                      s3_x;
  coord_t                      s3_y;
  logic                        s3_first;
  logic                        s3_last;
  // outline state
  logic                        close_pend;
  coord_t                      first_x;
  coord_t                      first_y;
  coord_t box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;

  logic out_free, take3, s3_ready, s2_ready, s1_ready;
  logic signed [SUM_BITS-1:0]  sum_x;
  logic signed [SUM_BITS-1:0]  sum_y;
  logic signed [XLAT_BITS-1:0] tx;
  logic signed [XLAT_BITS-1:0] ty;
  coord_t nmin_x, nmin_y, nmax_x, nmax_y;

  function automatic coord_t sat_coord(input logic signed [XLAT_BITS-1:0] v);
    logic in_range;
    in_range = (v[XLAT_BITS-1:COORD_BITS-1] ==
                {(XLAT_BITS - COORD_BITS + 1){v[XLAT_BITS-1]}});
    if (in_range) begin
      sat_coord = v[COORD_BITS-1:0];
    end else if (v[XLAT_BITS-1]) begin
      sat_coord = {1'b1, {(COORD_BITS - 1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_BITS - 1){1'b1}}};
    end
  endfunction

  assign out_free = !result_valid || !result_stall;
  assign take3    = s3_valid && out_free && !close_pend;
  assign s3_ready = !s3_valid || take3;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign q_pop    = !q_empty && s1_ready;

  always_comb begin
    sum_x = SUM_BITS'(s1_cdx) - SUM_BITS'(s1_sdy) + SUM_BITS'(Q15_HALF);
    sum_y = SUM_BITS'(s1_sdx) + SUM_BITS'(s1_cdy) + SUM_BITS'(Q15_HALF);
    tx    = XLAT_BITS'(s2_rx) + XLAT_BITS'(s2_px) + XLAT_BITS'(offset_x);
    ty    = XLAT_BITS'(s2_ry) + XLAT_BITS'(s2_py) + XLAT_BITS'(offset_y);
  end

  always_comb begin
    if (s3_first) begin
      nmin_x = s3_x;
      nmax_x = s3_x;
      nmin_y = s3_y;
      nmax_y = s3_y;
    end else begin
      nmin_x = (s3_x < box_min_x_q) ? s3_x : box_min_x_q;
      nmax_x = (s3_x > box_max_x_q) ? s3_x : box_max_x_q;
      nmin_y = (s3_y < box_min_y_q) ? s3_y : box_min_y_q;
      nmax_y = (s3_y > box_max_y_q) ? s3_y : box_max_y_q;
    end
  end

  assign box_min_x = box_min_x_q;
  assign box_min_y = box_min_y_q;
  assign box_max_x = box_max_x_q;
  assign box_max_y = box_max_y_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
      close_pend   <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_pop;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        if (close_pend) begin
          result_valid <= 1'b1;
          close_pend   <= 1'b0;
        end else if (s3_valid) begin
          result_valid <= 1'b1;
          close_pend   <= s3_last;
        end else begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cdx   <= PROD_BITS'(cos_value) * PROD_BITS'($signed(q_head.dx));
      s1_sdy   <= PROD_BITS'(sin_value) * PROD_BITS'($signed(q_head.dy));
      s1_sdx   <= PROD_BITS'(sin_value) * PROD_BITS'($signed(q_head.dx));
      s1_cdy   <= PROD_BITS'(cos_value) * PROD_BITS'($signed(q_head.dy));
      s1_px    <= q_head.px;
      s1_py    <= q_head.py;
      s1_first <= q_head.first;
      s1_last  <= q_head.last;
    end
    if (s2_ready && s1_valid) begin
      s2_rx    <= sum_x[SUM_BITS-1:TRIG_FRAC];
      s2_ry    <= sum_y[SUM_BITS-1:TRIG_FRAC];
      s2_px    <= s1_px;
      s2_py    <= s1_py;
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
    if (s3_ready && s2_valid) begin
      s3_x     <= sat_coord(tx);
      s3_y     <= sat_coord(ty);
      s3_first <= s2_first;
      s3_last  <= s2_last;
    end
    if (out_free && close_pend) begin
      out_x         <= first_x;
      out_y         <= first_y;
      closing_point <= 1'b1;
      result_last   <= 1'b1;
    end else if (take3) begin
      out_x         <= s3_x;
      out_y         <= s3_y;
      closing_point <= 1'b0;
      result_last   <= 1'b0;
      box_min_x_q   <= nmin_x;
      box_min_y_q   <= nmin_y;
      box_max_x_q   <= nmax_x;
      box_max_y_q   <= nmax_y;
      if (s3_first) begin
        first_x <= s3_x;
        first_y <= s3_y;
      end
    end
  end

  a_close_waits: assert property (@(posedge clk) disable iff (rst)
    close_pend |-> result_valid && !closing_point)
    else $error("closing word pending without a held vertex word");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
    else $error("bounding box corners out of order");

  a_close_point: assert property (@(posedge clk) disable iff (rst)
    result_valid && closing_point |-> (out_x == first_x) && (out_y == first_y))
    else $error("closing word does not repeat the first vertex");

endmodule

### rtl/polygon_rotate_translate_bbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_rotate_translate_bbox
// rotates polygon vertices about a pivot, translates them, tracks the box
// ----------------------------------------------------------------------------
// Vertices stream in as signed 24-bit fixed-point words, one per cycle at full
// rate while vertex_stall is low. Each vertex is rotated about the pivot (the
// polygon's first vertex, or the configured point when pivot_mode is set),
// shifted by the offset, saturated to 24 bits and sent out with the bounding
// box of the polygon so far. The word marked vertex_last gives two result
// words: the vertex itself, then a copy of the first transformed vertex with
// closing_point and result_last set; the closing word holds the pipeline
// while it goes out through the single output register. An accepted vertex
// passes through the input queue, then three pipeline stages (products,
// rounding, translate and saturate) ahead of the box and output register.
// Writing rotation_angle starts a sine/cosine evaluation on one shared 31x31
// multiplier; vertex_stall is high while it runs.
// ----------------------------------------------------------------------------
module polygon_rotate_translate_bbox
  import prtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // vertex words in
  input  logic        vertex_valid,
  output logic        vertex_stall,
  input  coord_t      vertex_x,
  input  coord_t      vertex_y,
  input  logic        vertex_last,
  // result words out
  output logic        result_valid,
  input  logic        result_stall,
  output coord_t      out_x,
  output coord_t      out_y,
  output coord_t      box_min_x,
  output coord_t      box_min_y,
  output coord_t      box_max_x,
  output coord_t      box_max_y,
  output logic        closing_point,
  output logic        result_last
);

  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_ROTATION_ANGLE = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_X       = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_Y       = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_PIVOT_MODE     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_FIXED_PIVOT_X  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_FIXED_PIVOT_Y  = 3'd5;

  // configuration registers
  logic [ANGLE_BITS-1:0] rotation_angle;
  coord_t                offset_x;
  coord_t                offset_y;
  logic                  pivot_mode;
  coord_t                fixed_pivot_x;
  coord_t                fixed_pivot_y;

  logic                        wr_en;
  logic [REG_IDX_BITS-1:0]     reg_idx;
  logic                        trig_start;
  logic                        trig_busy;
  logic signed [TRIG_BITS-1:0] cos_value;
  logic signed [TRIG_BITS-1:0] sin_value;

  logic       q_push;
  logic       q_pop;
  logic       q_empty;
  logic       q_full;
  vtx_entry_t push_entry;
  vtx_entry_t q_head;

  // register writes land on the access phase; no wait states
  assign pready     = 1'b1;
  assign reg_idx    = paddr[4:2];
  assign wr_en      = psel && penable && pwrite;
  assign trig_start = wr_en && (reg_idx == REG_ROTATION_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_angle <= '0;
      offset_x       <= '0;
      offset_y       <= '0;
      pivot_mode     <= 1'b0;
      fixed_pivot_x  <= '0;
      fixed_pivot_y  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROTATION_ANGLE: rotation_angle <= pwdata[ANGLE_BITS-1:0];
        REG_OFFSET_X:       offset_x       <= pwdata[COORD_BITS-1:0];
        REG_OFFSET_Y:       offset_y       <= pwdata[COORD_BITS-1:0];
        REG_PIVOT_MODE:     pivot_mode     <= pwdata[0];
        REG_FIXED_PIVOT_X:  fixed_pivot_x  <= pwdata[COORD_BITS-1:0];
        REG_FIXED_PIVOT_Y:  fixed_pivot_y  <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // readback, signed registers sign extended
  always_comb begin
    case (reg_idx)
      REG_ROTATION_ANGLE: prdata = 32'(rotation_angle);
      REG_OFFSET_X:       prdata = 32'(offset_x);
      REG_OFFSET_Y:       prdata = 32'(offset_y);
      REG_PIVOT_MODE:     prdata = 32'(pivot_mode);
      REG_FIXED_PIVOT_X:  prdata = 32'(fixed_pivot_x);
      REG_FIXED_PIVOT_Y:  prdata = 32'(fixed_pivot_y);
      default:            prdata = '0;
    endcase
  end

  // sine and cosine of the angle, recomputed on every angle write
  prtb_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .start     (trig_start),
    .angle     (pwdata[ANGLE_BITS-1:0]),
    .busy      (trig_busy),
    .cos_value (cos_value),
    .sin_value (sin_value)
  );

  // front: pivot latch and offsets, held off while the queue is full or the
  // trig values are being refreshed
  prtb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .vertex_valid  (vertex_valid),
    .vertex_stall  (vertex_stall),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .vertex_last   (vertex_last),
    .blocked       (q_full || trig_busy),
    .pivot_mode    (pivot_mode),
    .fixed_pivot_x (fixed_pivot_x),
    .fixed_pivot_y (fixed_pivot_y),
    .push          (q_push),
    .push_entry    (push_entry)
  );

  // decouples the front from output back pressure
  prtb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .empty      (q_empty),
    .full       (q_full),
    .head       (q_head)
  );

  // back: transform pipeline, bounding box and closing word
  prtb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .cos_value     (cos_value),
    .sin_value     (sin_value),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .box_min_x     (box_min_x),
    .box_min_y     (box_min_y),
    .box_max_x     (box_max_x),
    .box_max_y     (box_max_y),
    .closing_point (closing_point),
    .result_last   (result_last)
  );

endmodule
